>>> rtl/core/pcst_pkg.sv
`default_nettype none

package pcst_pkg;

    // input command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_PLAY    = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;
    localparam logic [2:0] CMD_SETLOOP = 3'd6;
    localparam logic [2:0] CMD_QUERY   = 3'd7;

    // deferred channel states
    localparam logic [2:0] ST_STOPPED   = 3'd0;
    localparam logic [2:0] ST_STOPPLAY  = 3'd1;
    localparam logic [2:0] ST_PAUSED    = 3'd2;
    localparam logic [2:0] ST_PAUSEPLAY = 3'd3;
    localparam logic [2:0] ST_PLAYING   = 3'd4;
    localparam logic [2:0] ST_STOPPING  = 3'd5;
    localparam logic [2:0] ST_PAUSING   = 3'd6;
    localparam logic [2:0] ST_RESTART   = 3'd7;

    // result actions
    localparam logic [2:0] ACT_ACK     = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_STOP    = 3'd2;
    localparam logic [2:0] ACT_PAUSE   = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;
    localparam logic [2:0] ACT_QUERY   = 3'd5;

    // listener notifications
    localparam logic [1:0] NT_NONE    = 2'd0;
    localparam logic [1:0] NT_STOPPED = 2'd1;
    localparam logic [1:0] NT_PAUSED  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic step_cmd;
        logic step_chan;
        logic step_final;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic cur_valid;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/pcst_ctrl.sv
`default_nettype none

module pcst_ctrl
    import pcst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // sequencing of one item
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.is_tick) begin
                    if (i_stat.out_free) begin
                        o_cmd.step_cmd = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.out_free || !i_stat.cur_valid) begin
                    o_cmd.step_chan = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.step_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcst_datapath.sv
`default_nettype none

module pcst_datapath
    import pcst_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [2:0]  i_cmd_code,
    input  wire logic [3:0]  i_slot,
    input  wire logic [15:0] i_elapsed_ms,
    input  wire logic [23:0] i_length_ms,
    input  wire logic        i_loop_flag,
    input  wire logic        i_has_listener,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_out_slot,
    output logic [2:0]       o_action,
    output logic [1:0]       o_notify,
    output logic [2:0]       o_out_state,
    output logic             o_out_looped,
    output logic             o_out_valid,
    output logic             o_last
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SX_W   = (IDX_W > 4) ? IDX_W : 4;
    localparam int LX_W   = (TIME_BITS > 24) ? TIME_BITS : 24;
    localparam int CD_W   = TIME_BITS + 1;
    localparam int DF_W   = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;
    localparam int WORD_W = CD_W + TIME_BITS + 5;
    localparam int LEN_LO = CD_W;
    localparam int LIS_B  = CD_W + TIME_BITS;
    localparam int LOOP_B = CD_W + TIME_BITS + 1;
    localparam logic signed [DF_W-1:0] CD_FLOOR =
        ~((DF_W'(1) << TIME_BITS) - DF_W'(1));

    // captured item
    logic [2:0]           r_cmd;
    logic [3:0]           r_slot;
    logic [15:0]          r_elapsed;
    logic [TIME_BITS-1:0] r_len;
    logic                 r_loop;
    logic                 r_lis;
    logic                 r_slot_ok;
    logic [IDX_W-1:0]     r_idx;

    // channel table
    logic [WORD_W-1:0]    mem [CHANNELS];
    logic [WORD_W-1:0]    r_rd;
    logic [CHANNELS-1:0]  r_chan_valid;

    // output register
    logic                 r_ov;
    logic [3:0]           r_o_slot;
    logic [2:0]           r_o_action;
    logic [1:0]           r_o_notify;
    logic [2:0]           r_o_state;
    logic                 r_o_looped;
    logic                 r_o_valid;
    logic                 r_o_last;

    logic [SX_W-1:0]      slot_x;
    logic [SX_W-1:0]      idx_x;
    logic [LX_W-1:0]      len_x;
    logic [IDX_W-1:0]     idx_inc;
    logic [IDX_W-1:0]     raddr;
    logic                 re;
    logic                 cur_valid;
    logic                 out_free;
    logic                 load;

    logic [2:0]           rd_state;
    logic                 rd_loop;
    logic                 rd_lis;
    logic [TIME_BITS-1:0] rd_len;
    logic signed [CD_W-1:0] rd_cd;
    logic signed [DF_W-1:0] cd_x;
    logic signed [DF_W-1:0] el_x;
    logic signed [DF_W-1:0] diff;
    logic signed [DF_W-1:0] sat;

    logic [2:0]           w_state;
    logic                 w_loop;
    logic                 w_lis;
    logic [TIME_BITS-1:0] w_len;
    logic [CD_W-1:0]      w_cd;
    logic                 we;
    logic                 set_valid;
    logic                 clr_valid;
    logic [3:0]           n_o_slot;
    logic [2:0]           n_o_action;
    logic [1:0]           n_o_notify;
    logic [2:0]           n_o_state;
    logic                 n_o_looped;
    logic                 n_o_valid;
    logic                 n_o_last;

    // index and slot conversions
    assign slot_x  = SX_W'(i_slot);
    assign idx_x   = SX_W'(r_idx);
    assign len_x   = LX_W'(i_length_ms);
    assign idx_inc = r_idx + IDX_W'(1);
    assign raddr   = i_cmd.accept
                   ? ((i_cmd_code == CMD_TICK) ? '0 : slot_x[IDX_W-1:0])
                   : idx_inc;
    assign re      = i_cmd.accept || (i_cmd.step_chan && !o_stat.idx_last);

    // status to controller
    assign cur_valid       = r_chan_valid[r_idx];
    assign out_free        = !r_ov || !i_stall;
    assign o_stat.is_tick  = (r_cmd == CMD_TICK);
    assign o_stat.cur_valid = cur_valid;
    assign o_stat.idx_last = (r_idx == IDX_W'(CHANNELS - 1));
    assign o_stat.out_free = out_free;

    // item capture and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd     <= i_cmd_code;
            r_slot    <= i_slot;
            r_elapsed <= i_elapsed_ms;
            r_len     <= len_x[TIME_BITS-1:0];
            r_loop    <= i_loop_flag;
            r_lis     <= i_has_listener;
            r_slot_ok <= ({28'd0, i_slot} < 32'(CHANNELS));
        end
        if (i_cmd.accept || i_cmd.step_chan) begin
            r_idx <= raddr;
        end
    end

    // table fields of the entry read
    assign rd_state = r_rd[WORD_W-1 -: 3];
    assign rd_loop  = r_rd[LOOP_B];
    assign rd_lis   = r_rd[LIS_B];
    assign rd_len   = r_rd[LEN_LO +: TIME_BITS];
    assign rd_cd    = r_rd[CD_W-1:0];

    // countdown with saturation at the floor
    assign cd_x = DF_W'(rd_cd);
    assign el_x = DF_W'(r_elapsed);
    assign diff = cd_x - el_x;
    assign sat  = (diff < CD_FLOOR) ? CD_FLOOR : diff;

    // command and settle logic
    always_comb begin
        w_state    = rd_state;
        w_loop     = rd_loop;
        w_lis      = rd_lis;
        w_len      = rd_len;
        w_cd       = rd_cd;
        we         = 1'b0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        n_o_slot   = r_slot;
        n_o_action = ACT_ACK;
        n_o_notify = NT_NONE;
        n_o_state  = ST_STOPPED;
        n_o_looped = 1'b0;
        n_o_valid  = 1'b0;
        n_o_last   = 1'b1;
        if (i_cmd.step_final) begin
            n_o_slot  = 4'd0;
            n_o_valid = 1'b1;
        end else if (i_cmd.step_chan) begin
            // tick visit of one channel
            n_o_slot = idx_x[3:0];
            n_o_last = 1'b0;
            we       = cur_valid;
            case (rd_state)
                ST_STOPPLAY, ST_PAUSEPLAY: begin
                    w_state    = ST_PLAYING;
                    w_cd       = signed'({1'b0, rd_len});
                    n_o_action = ACT_START;
                end
                ST_PLAYING: begin
                    if (!rd_loop) begin
                        w_cd = sat[CD_W-1:0];
                        if (sat <= 0) begin
                            w_state    = ST_STOPPED;
                            n_o_action = ACT_STOP;
                            n_o_notify = rd_lis ? NT_STOPPED : NT_NONE;
                        end
                    end
                end
                ST_STOPPING: begin
                    w_state    = ST_STOPPED;
                    n_o_action = ACT_STOP;
                    n_o_notify = rd_lis ? NT_STOPPED : NT_NONE;
                end
                ST_PAUSING: begin
                    w_state    = ST_PAUSED;
                    n_o_action = ACT_PAUSE;
                    n_o_notify = rd_lis ? NT_PAUSED : NT_NONE;
                end
                ST_RESTART: begin
                    w_state    = ST_PLAYING;
                    n_o_action = ACT_RESTART;
                    n_o_notify = rd_lis ? NT_STOPPED : NT_NONE;
                end
                default: begin
                end
            endcase
            n_o_state  = w_state;
            n_o_looped = rd_loop;
            n_o_valid  = 1'b1;
        end else if (!r_slot_ok) begin
            // out of range slot, ignored
        end else if (r_cmd == CMD_CREATE) begin
            w_state   = ST_STOPPED;
            w_loop    = 1'b0;
            w_lis     = r_lis;
            w_len     = r_len;
            w_cd      = '0;
            we        = 1'b1;
            set_valid = 1'b1;
            n_o_valid = 1'b1;
        end else if (!cur_valid) begin
            // channel not created, ignored
        end else if (r_cmd == CMD_RELEASE) begin
            clr_valid  = 1'b1;
            n_o_action = ACT_STOP;
            n_o_valid  = 1'b1;
        end else begin
            case (r_cmd)
                CMD_PLAY: begin
                    case (rd_state)
                        ST_STOPPED:  w_state = ST_STOPPLAY;
                        ST_PAUSED:   w_state = ST_PAUSEPLAY;
                        ST_STOPPING: w_state = ST_RESTART;
                        ST_PAUSING:  w_state = ST_PLAYING;
                        default:     w_state = rd_state;
                    endcase
                    we = 1'b1;
                end
                CMD_PAUSE: begin
                    case (rd_state)
                        ST_STOPPLAY:  w_state = ST_STOPPED;
                        ST_PAUSEPLAY: w_state = ST_PAUSED;
                        ST_PLAYING:   w_state = ST_PAUSING;
                        ST_RESTART:   w_state = ST_STOPPING;
                        default:      w_state = rd_state;
                    endcase
                    we = 1'b1;
                end
                CMD_STOP: begin
                    if (rd_state == ST_STOPPLAY) begin
                        w_state = ST_STOPPED;
                    end else if (rd_state != ST_STOPPED && rd_state != ST_STOPPING) begin
                        w_state = ST_STOPPING;
                    end
                    we = 1'b1;
                end
                CMD_SETLOOP: begin
                    w_loop = r_loop;
                    we     = 1'b1;
                end
                CMD_QUERY: begin
                    n_o_action = ACT_QUERY;
                end
                default: begin
                end
            endcase
            n_o_state  = w_state;
            n_o_looped = w_loop;
            n_o_valid  = 1'b1;
        end
    end

    assign load = i_cmd.step_cmd || i_cmd.step_final || (i_cmd.step_chan && cur_valid);

    // channel table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (we && (i_cmd.step_cmd || i_cmd.step_chan)) begin
            mem[r_idx] <= {w_state, w_loop, w_lis, w_len, w_cd};
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    // channel valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_valid <= '0;
        end else if (i_cmd.step_cmd) begin
            if (set_valid) begin
                r_chan_valid[r_idx] <= 1'b1;
            end else if (clr_valid) begin
                r_chan_valid[r_idx] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_slot   <= n_o_slot;
            r_o_action <= n_o_action;
            r_o_notify <= n_o_notify;
            r_o_state  <= n_o_state;
            r_o_looped <= n_o_looped;
            r_o_valid  <= n_o_valid;
            r_o_last   <= n_o_last;
        end
    end

    assign o_valid      = r_ov;
    assign o_out_slot   = r_o_slot;
    assign o_action     = r_o_action;
    assign o_notify     = r_o_notify;
    assign o_out_state  = r_o_state;
    assign o_out_looped = r_o_looped;
    assign o_out_valid  = r_o_valid;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

>>> rtl/core/playback_channel_state_table_core.sv
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------------
// input    | i_valid / o_stall  | i_cmd, i_slot, i_elapsed_ms, i_length_ms,
//          |                    | i_loop_flag, i_has_listener
// output   | o_valid / i_stall  | o_out_slot, o_action, o_notify, o_out_state,
//          |                    | o_out_looped, o_out_valid, o_last
//
// a command: the accepting cycle reads the table; once the output is free, the
// entry is updated and the result is loaded
// a tick: the accepting cycle reads the first channel, then the table writes back
// one channel per cycle while reading the next, as long as the output is free or
// the channel is not valid; then the closing item is loaded
// reset is synchronous, active low; the table needs no clearing pass (valid bits)
// o_stall is high from acceptance until the last result is loaded; a stalled output
// holds the scan on the current valid channel and on the closing item

`default_nettype none

module playback_channel_state_table_core
    import pcst_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [3:0]  i_slot,
    input  wire logic [15:0] i_elapsed_ms,
    input  wire logic [23:0] i_length_ms,
    input  wire logic        i_loop_flag,
    input  wire logic        i_has_listener,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_out_slot,
    output logic [2:0]       o_action,
    output logic [1:0]       o_notify,
    output logic [2:0]       o_out_state,
    output logic             o_out_looped,
    output logic             o_out_valid,
    output logic             o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller
    pcst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // channel table and result datapath
    pcst_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cmd_code     (i_cmd),
        .i_slot         (i_slot),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_length_ms    (i_length_ms),
        .i_loop_flag    (i_loop_flag),
        .i_has_listener (i_has_listener),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_slot     (o_out_slot),
        .o_action       (o_action),
        .o_notify       (o_notify),
        .o_out_state    (o_out_state),
        .o_out_looped   (o_out_looped),
        .o_out_valid    (o_out_valid),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/core/pcst_checker.sv
`default_nettype none

module pcst_checker
    import pcst_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [3:0]  o_out_slot,
    input wire logic [2:0]  o_action,
    input wire logic [1:0]  o_notify,
    input wire logic [2:0]  o_out_state,
    input wire logic        o_out_looped,
    input wire logic        o_out_valid,
    input wire logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_action) && $stable(o_out_slot)
            && $stable(o_notify) && $stable(o_last))
        else $error("stalled result changed");

    // an accepted item keeps the input busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not busy after acceptance");

    // an ignored command carries no action and no notification
    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_action == ACT_ACK && o_notify == NT_NONE
            && o_last)
        else $error("ignored command with action");

    // a notification only comes with a stop, pause or restart
    a_notify_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_notify != NT_NONE |->
            (o_action == ACT_STOP || o_action == ACT_PAUSE || o_action == ACT_RESTART)
            && !o_last)
        else $error("notification without matching action");

endmodule

bind playback_channel_state_table_core pcst_checker u_pcst_checker (.*);

`default_nettype wire
